### hw/rtl/binary_grid_ca_smoothing_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cave smoothing block
// Immediate-implication and next-cycle checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BINARY_GRID_CA_SMOOTHING_ASSERT_SVH
`define BINARY_GRID_CA_SMOOTHING_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define BGCS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("bgcs: same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define BGCS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("bgcs: next-cycle check failed");

`endif

### hw/rtl/bgcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_pkg
// Shared constants, types and helpers of the cave smoothing block.
// ----------------------------------------------------------------------------
package bgcs_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int RESET_DIM      = 64;
  localparam int RULE_PIVOT     = 4;
  localparam int DIM_W          = 9;
  localparam int COORD_W        = 8;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic bot;
    logic end_row;
    logic last_row;
  } tile_flags_t;

  typedef struct packed {
    logic [2:0]         mask;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] col_b;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] row_b;
    logic               wall_a;
    logic               wall_b;
    logic               wall_c;
    logic               done;
  } res_bundle_t;

  // written dimension -> last index, zero taken as one, saturated at maxv
  function automatic int unsigned dim_last(input logic [DIM_W-1:0] v,
                                           input int unsigned maxv);
    int unsigned vi;
    vi = 32'(v);
    if (vi == 0) begin
      return 0;
    end else if (vi > maxv) begin
      return maxv - 1;
    end else begin
      return vi - 1;
    end
  endfunction

  function automatic logic [3:0] count8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

### hw/rtl/bgcs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_in_if
// Tile input channel: one raster tile per word.
// ----------------------------------------------------------------------------
interface bgcs_in_if ();
  logic valid;
  logic ready;
  logic tile_is_wall;

  modport source (output valid, output tile_is_wall, input ready);
  modport sink (input valid, input tile_is_wall, output ready);
endinterface

### hw/rtl/bgcs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_out_if
// Result channel: one smoothed tile with its coordinates per word.
// ----------------------------------------------------------------------------
interface bgcs_out_if import bgcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               out_is_wall;
  logic               last_of_run;
  logic               frame_done;

  modport source (output valid, output out_col, output out_row, output out_is_wall,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input out_col, input out_row, input out_is_wall,
                input last_of_run, input frame_done, output ready);
endinterface

### hw/rtl/bgcs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_cfg_if
// Register write channel: index and data per word.
// ----------------------------------------------------------------------------
interface bgcs_cfg_if import bgcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/binary_grid_ca_smoothing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_grid_ca_smoothing
// One smoothing pass of the 4-5 cave automaton over a raster tile stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_tile  : one tile word per handshake, raster order, 1 wall / 0 floor.
//   out_tile : smoothed tiles with column and row; up to three words per
//              input tile, last_of_run on the final one, frame_done on the
//              grid's last tile. A tile leaves about one row after arrival;
//              last-row tiles leave as they arrive.
//   cfg_wr   : grid_width (index 0), grid_height (index 1); any write to
//              either restarts the frame. Always ready; write while idle.
// Path: an input word passes the stage input register, then the result register.
// Throughput: one input word per cycle while each tile yields at most one
//   result and out_tile is ready; the single output port sets the pace at
//   row ends and in the last row (two or three words per tile).
// Reset: sizes 64 x 64, position and window cleared; line store contents
//   are left as they are and are only read where they do not matter.
// A stalled receiver holds the result register and backs up to in_tile.
// ----------------------------------------------------------------------------
`include "binary_grid_ca_smoothing_assert.svh"

module binary_grid_ca_smoothing import bgcs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  bgcs_cfg_if.sink   cfg_wr,
  bgcs_in_if.sink    in_tile,
  bgcs_out_if.source out_tile
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_cnt, wlast;
  logic [RW-1:0] row_cnt;
  logic          restart, end_row, last_row, accept;
  logic          bundle_valid, bundle_take;
  res_bundle_t   bundle;

  bgcs_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_wr),
    .accept   (accept),
    .col_cnt  (col_cnt),
    .row_cnt  (row_cnt),
    .wlast    (wlast),
    .restart  (restart),
    .end_row  (end_row),
    .last_row (last_row)
  );

  bgcs_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_tile),
    .col_cnt      (col_cnt),
    .row_cnt      (row_cnt),
    .end_row      (end_row),
    .last_row     (last_row),
    .restart      (restart),
    .accept       (accept),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_take  (bundle_take)
  );

  bgcs_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_take  (bundle_take),
    .out_ch       (out_tile)
  );

  `BGCS_ASSERT_IMPL(a_col_in_row, clk, rst_n, 1'b1, col_cnt <= wlast)
  `BGCS_ASSERT_NEXT(a_cfg_restart, clk, rst_n, restart, (col_cnt == '0) && (row_cnt == '0))
  `BGCS_ASSERT_NEXT(a_accept_loads, clk, rst_n, accept, bundle_valid)
  `BGCS_ASSERT_IMPL(a_done_closes_run, clk, rst_n, out_tile.valid && out_tile.frame_done, out_tile.last_of_run)

endmodule

### hw/rtl/bgcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module bgcs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/bgcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_ctrl
// Grid size registers and raster position counters.
// ----------------------------------------------------------------------------
module bgcs_ctrl import bgcs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bgcs_cfg_if.sink                      cfg,
  input  logic                          accept,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_cnt,
  output logic [$clog2(MAX_HEIGHT)-1:0] row_cnt,
  output logic [$clog2(MAX_WIDTH)-1:0]  wlast,
  output logic                          restart,
  output logic                          end_row,
  output logic                          last_row
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int W_RST = (RESET_DIM > MAX_WIDTH)  ? MAX_WIDTH - 1  : RESET_DIM - 1;
  localparam int H_RST = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT - 1 : RESET_DIM - 1;

  logic [CW-1:0] wlast_r, col_r, col_nxt;
  logic [RW-1:0] hlast_r, row_r, row_nxt;
  logic          cfg_fire;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign restart   = cfg_fire && (cfg.index == REG_GRID_WIDTH ||
                                  cfg.index == REG_GRID_HEIGHT);

  assign end_row  = (col_r == wlast_r);
  assign last_row = (row_r == hlast_r);
  assign col_cnt  = col_r;
  assign row_cnt  = row_r;
  assign wlast    = wlast_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (end_row) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= CW'(W_RST);
      hlast_r <= RW'(H_RST);
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (cfg_fire && cfg.index == REG_GRID_WIDTH) begin
        wlast_r <= CW'(dim_last(cfg.data, MAX_WIDTH));
      end
      if (cfg_fire && cfg.index == REG_GRID_HEIGHT) begin
        hlast_r <= RW'(dim_last(cfg.data, MAX_HEIGHT));
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### hw/rtl/bgcs_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_stage
// Input register, line store, 3x3 window and 4-5 rule; builds the result set.
// ----------------------------------------------------------------------------
module bgcs_stage import bgcs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bgcs_in_if.sink                       in_ch,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col_cnt,
  input  logic [$clog2(MAX_HEIGHT)-1:0] row_cnt,
  input  logic                          end_row,
  input  logic                          last_row,
  input  logic                          restart,
  output logic                          accept,
  output res_bundle_t                   bundle,
  output logic                          bundle_valid,
  input  logic                          bundle_take
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
  localparam int RXW = (RW > COORD_W) ? RW : COORD_W;

  logic          s1_valid_r;
  logic [CW-1:0] c1_r;
  logic [RW-1:0] r1_r;
  tile_flags_t   fl1_r;
  logic          fwd_r;
  logic [1:0]    fwd_data_r;
  logic [8:0]    window_r, win_nxt;
  logic [1:0]    ram_q, rd_word, wr_word;
  logic          s1_adv, top, mid, centre, inner;
  logic [3:0]    walls;
  logic [CXW-1:0] ca_x, cb_x;
  logic [RXW-1:0] ra_x, rb_x;

  assign s1_adv       = s1_valid_r && bundle_take;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;
  assign bundle_valid = s1_valid_r;

  // same-address bypass: only hit on single-column grids
  assign rd_word = fwd_r ? fwd_data_r : ram_q;
  assign top     = rd_word[1];
  assign mid     = rd_word[0];
  assign wr_word = {mid, fl1_r.bot};

  bgcs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (c1_r),
    .wr_data (wr_word),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (ram_q)
  );

  assign win_nxt = {fl1_r.bot, mid, top, window_r[8:3]};
  assign centre  = win_nxt[4];
  assign walls   = count8({win_nxt[8:5], win_nxt[3:0]});
  assign inner   = (r1_r >= RW'(2)) && (c1_r >= CW'(2));

  assign ca_x = CXW'(c1_r - CW'(1));
  assign cb_x = CXW'(c1_r);
  assign ra_x = RXW'(r1_r - RW'(1));
  assign rb_x = RXW'(r1_r);

  always_comb begin
    bundle.mask[0] = (r1_r != '0) && (c1_r != '0);
    bundle.mask[1] = (r1_r != '0) && fl1_r.end_row;
    bundle.mask[2] = fl1_r.last_row;
    bundle.col_a   = ca_x[COORD_W-1:0];
    bundle.col_b   = cb_x[COORD_W-1:0];
    bundle.row_a   = ra_x[COORD_W-1:0];
    bundle.row_b   = rb_x[COORD_W-1:0];
    if (!inner) begin
      bundle.wall_a = centre;
    end else if (walls > 4'(RULE_PIVOT)) begin
      bundle.wall_a = 1'b1;
    end else if (walls < 4'(RULE_PIVOT)) begin
      bundle.wall_a = 1'b0;
    end else begin
      bundle.wall_a = centre;
    end
    bundle.wall_b = mid;
    bundle.wall_c = fl1_r.bot;
    bundle.done   = fl1_r.end_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      window_r   <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (restart) begin
        window_r <= '0;
      end else if (s1_adv) begin
        window_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c1_r           <= col_cnt;
      r1_r           <= row_cnt;
      fl1_r.bot      <= in_ch.tile_is_wall;
      fl1_r.end_row  <= end_row;
      fl1_r.last_row <= last_row;
      fwd_r          <= s1_adv && (c1_r == col_cnt);
      fwd_data_r     <= wr_word;
    end
  end

endmodule

### hw/rtl/bgcs_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_emit
// Result register: hands out the up to three results of one tile in order.
// ----------------------------------------------------------------------------
module bgcs_emit import bgcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  res_bundle_t bundle,
  input  logic        bundle_valid,
  output logic        bundle_take,
  bgcs_out_if.source  out_ch
);

  logic [2:0]  mask_r;
  res_bundle_t b_r;
  logic        fire, last;

  assign out_ch.valid = (mask_r != 3'b000);
  assign fire         = out_ch.valid && out_ch.ready;
  assign last         = ((mask_r & (mask_r - 3'd1)) == 3'b000);
  assign bundle_take  = (mask_r == 3'b000) || (fire && last);

  assign out_ch.last_of_run = last;

  always_comb begin
    if (mask_r[0]) begin
      out_ch.out_col     = b_r.col_a;
      out_ch.out_row     = b_r.row_a;
      out_ch.out_is_wall = b_r.wall_a;
      out_ch.frame_done  = 1'b0;
    end else if (mask_r[1]) begin
      out_ch.out_col     = b_r.col_b;
      out_ch.out_row     = b_r.row_a;
      out_ch.out_is_wall = b_r.wall_b;
      out_ch.frame_done  = 1'b0;
    end else begin
      out_ch.out_col     = b_r.col_b;
      out_ch.out_row     = b_r.row_b;
      out_ch.out_is_wall = b_r.wall_c;
      out_ch.frame_done  = b_r.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'b000;
    end else if (bundle_take && bundle_valid) begin
      mask_r <= bundle.mask;
    end else if (fire) begin
      mask_r <= mask_r & (mask_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_take && bundle_valid) begin
      b_r <= bundle;
    end
  end

endmodule
